### rtl/text_console_char_engine_core_macros.svh
// ----------------------------------------------------------------------------
// Text console char engine - assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TCCE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCCE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define TCCE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console char engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int LOC_W       = 11;
    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTR  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ATTR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DELETE    = 8'h7F;

    localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR  = 8'd14;
    localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'd15;
    localparam logic [CELL_W-1:0] RESET_BLANK      = {RESET_BLANK_ATTR, CH_SPACE};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR
    } t_state;

    typedef enum logic [1:0] {
        SWEEP_NONE,
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } t_sweep;

    typedef struct packed {
        logic   capture;
        logic   put;
        logic   home;
        logic   load_out;
        t_sweep sweep;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                scroll;
        logic                sweep_done;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: request handshake, screen sweeps and output register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ctrl
    import tcce_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '{capture: 1'b0, put: 1'b0, home: 1'b0, load_out: 1'b0,
                        sweep: SWEEP_NONE};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep = SWEEP_INIT;
                if (i_status.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_status.action)
                    ACT_PUT: begin
                        o_cmd.put = 1'b1;
                        if (i_status.scroll) begin
                            n_state = ST_SCROLL;
                        end else begin
                            o_cmd.load_out = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.home = 1'b1;
                        n_state    = ST_CLEAR;
                    end
                    default: begin
                        o_cmd.load_out = 1'b1;
                        n_state        = ST_IDLE;
                    end
                endcase
            end
            ST_SCROLL: begin
                o_cmd.sweep = SWEEP_SCROLL;
                if (i_status.sweep_done) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.sweep = SWEEP_CLEAR;
                if (i_status.sweep_done) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/tcce_dp.sv
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: cursor, attributes, screen RAM, sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_dp
    import tcce_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [ACTION_W-1:0]    i_action,
    input  wire logic [CHAR_W-1:0]      i_char_code,
    input  wire logic [INDEX_W-1:0]     i_cell_index,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    output logic      [LOC_W-1:0]       o_cursor_pos,
    output logic      [CELL_W-1:0]      o_cell_value
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = AW + 1;
    localparam int IW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int TW    = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = $clog2(TAB_STOP);

    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [PW-1:0]       r_phase, n_phase;
    logic [ATTR_W-1:0]   r_text_attr, n_text_attr;
    logic [ATTR_W-1:0]   r_blank_attr, n_blank_attr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ACTION_W-1:0] r_action;
    logic [CHAR_W-1:0]   r_code;
    logic [INDEX_W-1:0]  r_index;
    logic [LOC_W-1:0]    r_loc;
    logic [CELL_W-1:0]   r_value;

    logic [TW-1:0]     t_col;
    logic [RW-1:0]     t_row;
    logic [PW-1:0]     t_phase;
    logic              line_adv;
    logic              print;
    logic              scroll;
    logic [AW-1:0]     put_addr;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  scroll_raddr;
    logic [CELL_W-1:0] blank;
    logic [IW-1:0]     loc_w;
    logic              in_range;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // r_phase tracks column modulo the tab stop
    always_comb begin
        t_col    = TW'(r_col);
        t_row    = r_row;
        t_phase  = r_phase;
        line_adv = 1'b0;
        print    = 1'b0;
        scroll   = 1'b0;
        case (r_code) inside
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    t_col   = TW'(r_col) - TW'(1);
                    t_phase = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
                end
            end
            CH_TAB: begin
                t_col   = TW'(r_col) + TW'(TAB_STOP) - TW'(r_phase);
                t_phase = '0;
            end
            CH_CR: begin
                t_col   = '0;
                t_phase = '0;
            end
            CH_LF: begin
                t_col    = '0;
                t_phase  = '0;
                line_adv = 1'b1;
            end
            [CH_SPACE:CH_DELETE]: begin
                print   = 1'b1;
                t_col   = TW'(r_col) + TW'(1);
                t_phase = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
            end
            default: ;
        endcase
        if (t_col >= TW'(COLUMNS)) begin
            t_col    = '0;
            t_phase  = '0;
            line_adv = 1'b1;
        end
        if (line_adv) begin
            if (r_row == RW'(ROWS - 1)) begin
                scroll = 1'b1;
            end else begin
                t_row = r_row + RW'(1);
            end
        end
    end

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_phase      = r_phase;
        n_text_attr  = r_text_attr;
        n_blank_attr = r_blank_attr;
        if (i_cmd.home) begin
            n_col   = '0;
            n_row   = '0;
            n_phase = '0;
        end else if (i_cmd.put) begin
            n_col   = t_col[CW-1:0];
            n_row   = t_row;
            n_phase = t_phase;
        end
        if (i_cfg_we && i_cfg_index == REG_TEXT_ATTR) begin
            n_text_attr = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_index == REG_BLANK_ATTR) begin
            n_blank_attr = i_cfg_data;
        end
        n_cnt = (i_cmd.sweep != SWEEP_NONE) ? r_cnt + CNT_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_phase      <= '0;
            r_text_attr  <= RESET_TEXT_ATTR;
            r_blank_attr <= RESET_BLANK_ATTR;
            r_cnt        <= '0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_phase      <= n_phase;
            r_text_attr  <= n_text_attr;
            r_blank_attr <= n_blank_attr;
            r_cnt        <= n_cnt;
        end
    end

    // Sweeps write one cell behind the counter so scroll can use the read latency
    assign put_addr     = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign cnt_m1       = r_cnt - CNT_W'(1);
    assign scroll_raddr = r_cnt + CNT_W'(COLUMNS);
    assign blank        = {r_blank_attr, CH_SPACE};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_m1[AW-1:0];
        ram_wdata = blank;
        ram_raddr = AW'(i_cell_index);
        unique case (i_cmd.sweep)
            SWEEP_NONE: begin
                if (i_cmd.put && print) begin
                    ram_we    = 1'b1;
                    ram_waddr = put_addr;
                    ram_wdata = {r_text_attr, r_code};
                end
            end
            SWEEP_INIT: begin
                ram_we    = (r_cnt != '0);
                ram_wdata = RESET_BLANK;
            end
            SWEEP_CLEAR: begin
                ram_we = (r_cnt != '0);
            end
            SWEEP_SCROLL: begin
                ram_we    = (r_cnt != '0);
                ram_raddr = scroll_raddr[AW-1:0];
                if (r_cnt <= CNT_W'(CELLS - COLUMNS)) begin
                    ram_wdata = ram_rdata;
                end
            end
            default: ;
        endcase
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign loc_w    = IW'(n_row) * IW'(COLUMNS) + IW'(n_col);
    assign in_range = IW'(r_index) < IW'(CELLS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_code   <= i_char_code;
            r_index  <= i_cell_index;
        end
        if (i_cmd.load_out) begin
            r_loc   <= loc_w[LOC_W-1:0];
            r_value <= (r_action == ACT_READ && in_range) ? ram_rdata : '0;
        end
    end

    assign o_status.action     = r_action;
    assign o_status.scroll     = scroll;
    assign o_status.sweep_done = (r_cnt == CNT_W'(CELLS));

    assign o_cursor_pos = r_loc;
    assign o_cell_value = r_value;

endmodule

`default_nettype wire

### rtl/text_console_char_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_char_engine_core
// Text-mode terminal: character put with cursor control, clear and cell read.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready    | action, char_code, cell_index
//   out     | output    | o_out_valid / i_out_ready  | cursor_pos, cell_value
//   cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Put and read requests pass through capture, then one screen RAM access.
// Clear, and a put that scrolls, sweep the RAM one cell per cycle through the
// single write port. After reset a clearing pass over the whole screen runs
// before the first request is taken. A result waiting in the output register
// holds off the next request only while i_out_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_char_engine_core_macros.svh"

module text_console_char_engine_core
    import tcce_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [ACTION_W-1:0]    i_action,
    input  wire logic [CHAR_W-1:0]      i_char_code,
    input  wire logic [INDEX_W-1:0]     i_cell_index,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [LOC_W-1:0]       o_cursor_pos,
    output logic      [CELL_W-1:0]      o_cell_value
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tcce_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value)
    );

    `TCCE_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                     !o_in_ready, "request taken while result stalled")
    `TCCE_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready,
                     !o_in_ready, "second request taken while busy")
    `TCCE_ASSERT_IMP(a_load_empty, i_clk, i_rst_n, w_cmd.load_out,
                     !o_out_valid, "result loaded over a pending result")
    `TCCE_ASSERT_IMP(a_sweep_blocks, i_clk, i_rst_n, w_cmd.sweep != SWEEP_NONE,
                     !o_in_ready, "request taken during screen sweep")

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - text console char engine testbench
// Drives put, clear and read requests through the valid/ready input channel,
// tracks screen cells, cursor and attributes in a scoreboard class, and checks
// every cursor/cell result in order. Phases vary attributes and idling, one
// holds off the receiver long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import tcce_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_STOP     = 8;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int DRAIN_CYCLES = 2 * CELLS + 16;
    localparam int PHASE_ITEMS  = 85;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_value;
    } t_status;

    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELLS];
        int                col;
        int                row;
        logic [ATTR_W-1:0] text_attr;
        logic [ATTR_W-1:0] blank_attr;
        t_status           expected_q[$];
        int                errors;

        function new();
            text_attr  = RESET_TEXT_ATTR;
            blank_attr = RESET_BLANK_ATTR;
            errors     = 0;
            blank_all();
        endfunction

        function void set_attrs(logic [ATTR_W-1:0] text, logic [ATTR_W-1:0] blank);
            text_attr  = text;
            blank_attr = blank;
        endfunction

        function void blank_all();
            foreach (screen[i]) screen[i] = {blank_attr, CH_SPACE};
            col = 0;
            row = 0;
        endfunction

        function void scroll_up();
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {blank_attr, CH_SPACE};
            row = ROWS - 1;
        endfunction

        function void put_char(logic [CHAR_W-1:0] code);
            case (code)
                CH_BACKSPACE: if (col != 0) col--;
                CH_TAB:       col = (col / TAB_STOP + 1) * TAB_STOP;
                CH_CR:        col = 0;
                CH_LF: begin
                    col = 0;
                    row++;
                end
                default: begin
                    if (code >= CH_SPACE && code <= CH_DELETE) begin
                        screen[row * COLUMNS + col] = {text_attr, code};
                        col++;
                    end
                end
            endcase
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= ROWS) scroll_up();
        endfunction

        function logic [LOC_W-1:0] cursor_pos();
            return LOC_W'(row * COLUMNS + col);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] code,
                                   logic [INDEX_W-1:0] idx);
            t_status res;
            res.cell_value = '0;
            case (act)
                ACT_PUT:   put_char(code);
                ACT_CLEAR: blank_all();
                ACT_READ:  if (idx < CELLS) res.cell_value = screen[idx];
                default:   ;
            endcase
            res.cursor_pos = cursor_pos();
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [LOC_W-1:0] loc, logic [CELL_W-1:0] value);
            t_status want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: cursor_pos %0d, cell_value 0x%04h", loc, value);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (loc !== want.cursor_pos) begin
                $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, loc);
                errors++;
            end
            if (value !== want.cell_value) begin
                $error("cell_value: expected 0x%04h, actual 0x%04h", want.cell_value, value);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = REG_TEXT_ATTR;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic [ACTION_W-1:0]    i_action     = ACT_PUT;
    logic [CHAR_W-1:0]      i_char_code  = '0;
    logic [INDEX_W-1:0]     i_cell_index = '0;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [LOC_W-1:0]       o_cursor_pos;
    logic [CELL_W-1:0]      o_cell_value;

    console_scoreboard sb;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_cycles    = 0;
    int                items_sent     = 0;

    text_console_char_engine_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready)
                sb.check_result(o_cursor_pos, o_cell_value);
            if (i_in_valid && o_in_ready === 1'b1)
                sb.note_request(i_action, i_char_code, i_cell_index);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] any_code();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
    endfunction

    // mostly printable text, with cursor controls and ignored codes mixed in
    function automatic logic [CHAR_W-1:0] text_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78) return CHAR_W'($urandom_range(32, 127));
        if (pick < 83) return CH_TAB;
        if (pick < 88) return CH_BACKSPACE;
        if (pick < 90) return CH_CR;
        if (pick < 95) return CHAR_W'($urandom_range(0, 31));
        return CHAR_W'($urandom_range(128, 255));
    endfunction

    function automatic logic [INDEX_W-1:0] read_index();
        int pick;
        int near;
        pick = $urandom_range(99);
        if (pick < 40) return INDEX_W'($urandom_range(0, CELLS - 1));
        if (pick < 65) return INDEX_W'($urandom_range((ROWS - 4) * COLUMNS, CELLS - 1));
        if (pick < 85) begin
            near = int'(sb.cursor_pos()) - int'($urandom_range(0, COLUMNS));
            return INDEX_W'(near < 0 ? 0 : near);
        end
        return INDEX_W'($urandom_range(CELLS, 2 ** INDEX_W - 1));
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] code,
                                input logic [INDEX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_char_code  <= code;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || o_in_ready !== 1'b1);
    endtask

    task automatic write_attrs(input logic [ATTR_W-1:0] text, input logic [ATTR_W-1:0] blank);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TEXT_ATTR;
        i_cfg_data  <= text;
        @(posedge i_clk);
        i_cfg_index <= REG_BLANK_ATTR;
        i_cfg_data  <= blank;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_attrs(text, blank);
    endtask

    task automatic random_group();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 65) begin
            len = $urandom_range(0, 90);
            repeat (len) send_request(ACT_PUT, text_code(), any_index());
            case ($urandom_range(3))
                0: ;
                1: send_request(ACT_PUT, CH_LF, any_index());
                2: begin
                    send_request(ACT_PUT, CH_CR, any_index());
                    send_request(ACT_PUT, CH_LF, any_index());
                end
                default: send_request(ACT_PUT, CH_LF, any_index());
            endcase
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 30)) send_request(ACT_PUT, CH_LF, any_index());
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) send_request(ACT_READ, any_code(), read_index());
        end else if (pick < 91) begin
            send_request(ACT_CLEAR, any_code(), any_index());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(2))
                    0: send_request(ACT_UNUSED, any_code(), any_index());
                    1: send_request(ACT_PUT, CHAR_W'($urandom_range(128, 255)), any_index());
                    default: send_request(ACTION_W'($urandom_range(3)), any_code(), any_index());
                endcase
            end
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input logic [ATTR_W-1:0] text,
                             input logic [ATTR_W-1:0] blank, input int hold);
        int target;
        settle();
        write_attrs(text, blank);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        hold_cycles    = hold;
        target         = items_sent + PHASE_ITEMS;
        while (items_sent < target) random_group();
    endtask

    task automatic directed_requests();
        send_request(ACT_READ, any_code(), INDEX_W'(0));
        send_request(ACT_READ, any_code(), INDEX_W'(CELLS - 1));
        send_request(ACT_READ, any_code(), INDEX_W'(CELLS));
        send_request(ACT_READ, any_code(), '1);
        send_request(ACT_PUT, CH_SPACE, any_index());
        send_request(ACT_PUT, CH_DELETE, any_index());
        send_request(ACT_PUT, 8'h41, any_index());
        send_request(ACT_PUT, 8'h80, any_index());
        send_request(ACT_PUT, 8'hFF, any_index());
        send_request(ACT_PUT, 8'h00, any_index());
        send_request(ACT_PUT, 8'h1F, any_index());
        repeat (4) send_request(ACT_PUT, CH_BACKSPACE, any_index());
        send_request(ACT_PUT, CH_TAB, any_index());
        send_request(ACT_PUT, CH_TAB, any_index());
        send_request(ACT_PUT, CH_CR, any_index());
        send_request(ACT_PUT, CH_LF, any_index());
        send_request(ACT_UNUSED, any_code(), any_index());
        send_request(ACT_READ, any_code(), INDEX_W'(0));
        send_request(ACT_READ, any_code(), INDEX_W'(1));
        send_request(ACT_READ, any_code(), INDEX_W'(2));
        send_request(ACT_CLEAR, any_code(), any_index());
        send_request(ACT_READ, any_code(), INDEX_W'(1));
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset starts a clearing pass over the whole screen
        do @(posedge i_clk); while (o_in_ready !== 1'b1);

        directed_requests();

        run_phase(0, 0, 8'h00, 8'h00, 0);
        run_phase(68, 0, 8'hFF, 8'hFF, 0);
        run_phase(0, 68, ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 0);
        run_phase(6, 6, ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 0);
        run_phase(0, 0, ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), HOLD_CYCLES);
        run_phase(68, 68, ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 0);

        recv_stall_pct = 0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
